### sv/barrett_modular_multiplier_64_macros.svh
// Assertion macros for the Barrett modular multiplier.
`ifndef BARRETT_MODULAR_MULTIPLIER_64_MACROS_SVH
`define BARRETT_MODULAR_MULTIPLIER_64_MACROS_SVH

`ifndef SYNTH
`define BMM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BMM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/bmm_pkg.sv
// Shared types and constants of the Barrett modular multiplier.
package bmm_pkg;

   localparam int WORD_WIDTH  = 64;
   localparam int HALF_WIDTH  = 32;
   localparam int STAGE_COUNT = 10;

   typedef enum logic [1:0] {
      CSR_MODULUS    = 2'd0,
      CSR_RECIPROCAL = 2'd1,
      CSR_EXPONENT   = 2'd2
   } bmm_csr_index_type;

   typedef struct packed {
      logic pp;
      logic sum;
   } bmm_mul_en_type;

endpackage

### sv/barrett_modular_multiplier_64.sv
// Barrett modular multiplier, 64-bit: top level with pipeline control and registers.
//
// Accepts one operand pair per clock unless every stage is full and the output
// is held, and returns one reduced product per pair, in order, through ten
// register stages; the last stage drives rsp_tdata. Every
// 64-bit multiplication is split into 32 x 32 partial products with a register
// stage for the partial products and one for their sum; the quotient estimate
// add, the exponent shift, the subtraction and the final correction each take a
// stage of their own. Each stage holds a valid bit and advances whenever the stage
// after it is empty or moving, so bubbles close up and input keeps flowing while a
// result waits. Operands are taken as below the modulus and the reciprocal as
// floor(2^exponent / modulus); nothing checks this. Registers sit on the APB port
// at byte addresses 0 (modulus), 8 (reciprocal) and 16 (exponent), and should be
// written only while the pipeline is empty.
`include "barrett_modular_multiplier_64_macros.svh"

module barrett_modular_multiplier_64 import bmm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // operand_a [63:0], operand_b [127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // product_mod [63:0]
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);

   logic [WORD_WIDTH-1:0]  modulus_ff, reciprocal_ff;
   logic [6:0]             exponent_ff;
   bmm_csr_index_type      csr_index;
   logic                   csr_write;

   logic [STAGE_COUNT-1:0] valid_ff, valid_in, stage_en;

   logic [2*WORD_WIDTH-1:0] p_full, t_full, u_full;
   logic [2*WORD_WIDTH-1:0] q_ff, q_in;
   logic [WORD_WIDTH-1:0]   q_low_ff, q_low_in;
   logic [2*WORD_WIDTH-1:0] q_shifted;
   logic [5:0]              shift_amt;
   logic [WORD_WIDTH-1:0]   qm;
   logic [WORD_WIDTH-1:0]   r_ff, r_in;
   logic [WORD_WIDTH-1:0]   out_ff, out_in;
   logic [WORD_WIDTH-1:0]   plo_ff [2:7];

   bmm_mul_en_type en_ab, en_tr, en_qm;

   assign csr_pready = 1'b1;
   assign csr_index  = bmm_csr_index_type'(csr_paddr[4:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= 64'd1;
         reciprocal_ff <= 64'd0;
         exponent_ff   <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS:    modulus_ff    <= csr_pwdata;
            CSR_RECIPROCAL: reciprocal_ff <= csr_pwdata;
            CSR_EXPONENT:   exponent_ff   <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_MODULUS:    csr_prdata = modulus_ff;
         CSR_RECIPROCAL: csr_prdata = reciprocal_ff;
         CSR_EXPONENT:   csr_prdata = {57'd0, exponent_ff};
         default:        csr_prdata = 64'd0;
      endcase
   end

   // advance a stage when the next one is empty or moving
   always_comb begin
      stage_en[STAGE_COUNT-1] = !valid_ff[STAGE_COUNT-1] || rsp_tready;
      for (int i = STAGE_COUNT - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = req_tvalid;
      for (int i = 1; i < STAGE_COUNT; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGE_COUNT; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_tready = stage_en[0];

   assign en_ab = '{pp: stage_en[0], sum: stage_en[1]};
   assign en_tr = '{pp: stage_en[2], sum: stage_en[3]};
   assign en_qm = '{pp: stage_en[6], sum: stage_en[7]};

   bmm_mul64 u_mul_ab (
      .clock   (clock),
      .en      (en_ab),
      .a       (req_tdata[63:0]),
      .b       (req_tdata[127:64]),
      .product (p_full)
   );

   bmm_mul64 u_mul_t (
      .clock   (clock),
      .en      (en_tr),
      .a       (p_full[WORD_WIDTH-1:0]),
      .b       (reciprocal_ff),
      .product (t_full)
   );

   bmm_mul64 u_mul_u (
      .clock   (clock),
      .en      (en_tr),
      .a       (p_full[2*WORD_WIDTH-1:WORD_WIDTH]),
      .b       (reciprocal_ff),
      .product (u_full)
   );

   always_comb begin
      q_in      = u_full + {{WORD_WIDTH{1'b0}}, t_full[2*WORD_WIDTH-1:WORD_WIDTH]};
      shift_amt = exponent_ff[6] ? exponent_ff[5:0] : 6'd0;
      q_shifted = q_ff >> shift_amt;
      q_low_in  = q_shifted[WORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         q_ff <= q_in;
      end
      if (stage_en[5]) begin
         q_low_ff <= q_low_in;
      end
   end

   bmm_mul64_lo u_mul_qm (
      .clock   (clock),
      .en      (en_qm),
      .a       (q_low_ff),
      .b       (modulus_ff),
      .product (qm)
   );

   // carry the low product word alongside the quotient path
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         plo_ff[2] <= p_full[WORD_WIDTH-1:0];
      end
      for (int i = 3; i <= 7; i++) begin
         if (stage_en[i]) begin
            plo_ff[i] <= plo_ff[i-1];
         end
      end
   end

   always_comb begin
      r_in   = plo_ff[7] - qm;
      out_in = (r_ff >= modulus_ff) ? (r_ff - modulus_ff) : r_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         r_ff <= r_in;
      end
      if (stage_en[9]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = valid_ff[STAGE_COUNT-1];
   assign rsp_tdata  = out_ff;

   `BMM_ASSERT_NEXT(a_accept_fills_first, clock, reset, req_tvalid && req_tready, valid_ff[0])
   `BMM_ASSERT_IMPLY(a_backpressure_full, clock, reset, !req_tready, &valid_ff)
   `BMM_ASSERT_NEXT(a_stall_keeps_stage, clock, reset,
      valid_ff[STAGE_COUNT-1] && !rsp_tready && valid_ff[STAGE_COUNT-2],
      valid_ff[STAGE_COUNT-2])

endmodule

### sv/bmm_mul64.sv
// Two-stage 64 x 64 -> 128 multiplier built from 32 x 32 partial products.
module bmm_mul64 import bmm_pkg::*; (
   input  logic                      clock,
   input  bmm_mul_en_type            en,
   input  logic [WORD_WIDTH-1:0]     a,
   input  logic [WORD_WIDTH-1:0]     b,
   output logic [2*WORD_WIDTH-1:0]   product
);

   logic [WORD_WIDTH-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic [2*WORD_WIDTH-1:0] prod_ff, prod_in;

   always_ff @(posedge clock) begin
      if (en.pp) begin
         ll_ff <= a[HALF_WIDTH-1:0]          * b[HALF_WIDTH-1:0];
         lh_ff <= a[HALF_WIDTH-1:0]          * b[WORD_WIDTH-1:HALF_WIDTH];
         hl_ff <= a[WORD_WIDTH-1:HALF_WIDTH] * b[HALF_WIDTH-1:0];
         hh_ff <= a[WORD_WIDTH-1:HALF_WIDTH] * b[WORD_WIDTH-1:HALF_WIDTH];
      end
   end

   always_comb begin
      prod_in = {hh_ff, {WORD_WIDTH{1'b0}}}
              + {{HALF_WIDTH{1'b0}}, lh_ff, {HALF_WIDTH{1'b0}}}
              + {{HALF_WIDTH{1'b0}}, hl_ff, {HALF_WIDTH{1'b0}}}
              + {{WORD_WIDTH{1'b0}}, ll_ff};
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

### sv/bmm_mul64_lo.sv
// Two-stage 64 x 64 multiplier that keeps the low 64 bits of the product.
module bmm_mul64_lo import bmm_pkg::*; (
   input  logic                  clock,
   input  bmm_mul_en_type        en,
   input  logic [WORD_WIDTH-1:0] a,
   input  logic [WORD_WIDTH-1:0] b,
   output logic [WORD_WIDTH-1:0] product
);

   logic [WORD_WIDTH-1:0] ll_ff;
   logic [HALF_WIDTH-1:0] lh_ff, hl_ff;
   logic [HALF_WIDTH-1:0] mid;
   logic [WORD_WIDTH-1:0] prod_ff, prod_in;
   logic [WORD_WIDTH-1:0] lh_full, hl_full;

   always_comb begin
      lh_full = a[HALF_WIDTH-1:0]          * b[WORD_WIDTH-1:HALF_WIDTH];
      hl_full = a[WORD_WIDTH-1:HALF_WIDTH] * b[HALF_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.pp) begin
         ll_ff <= a[HALF_WIDTH-1:0] * b[HALF_WIDTH-1:0];
         lh_ff <= lh_full[HALF_WIDTH-1:0];
         hl_ff <= hl_full[HALF_WIDTH-1:0];
      end
   end

   always_comb begin
      mid     = lh_ff + hl_ff;
      prod_in = ll_ff + {mid, {HALF_WIDTH{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

### dv/barrett_modular_multiplier_64_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 64-bit Barrett modular multiplier stream block.
module barrett_modular_multiplier_64_test import bmm_pkg::*;;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata   = '0;     // operand_a [63:0], operand_b [127:64]
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [63:0]   rsp_tdata;            // product_mod [63:0]
   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [4:0]    csr_paddr   = '0;
   logic [63:0]   csr_pwdata  = '0;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   logic [63:0]   modulus_setting    = 64'd1;
   logic [63:0]   reciprocal_setting = 64'd0;
   logic [6:0]    exponent_setting   = 7'd64;

   logic [63:0]   expected_residues[$];
   logic [63:0]   oldest_residue;

   int            error_count        = 0;
   int            items_sent         = 0;
   int            results_seen       = 0;
   int            register_writes    = 0;
   int            input_stall_cycles = 0;
   int            cycle_count        = 0;
   int unsigned   sink_hold_request  = 0;
   bit            source_gaps        = 1'b0;
   bit            sink_gaps          = 1'b0;

   barrett_modular_multiplier_64 dut (.*);

   always #1 clock = ~clock;

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned idle_length();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [63:0] barrett_residue(input logic [63:0] operand_a,
                                                   input logic [63:0] operand_b);
      logic [127:0] full_product;
      logic [127:0] low_partial;
      logic [127:0] estimate;
      logic [63:0]  quotient;
      logic [63:0]  residue;
      logic [6:0]   shift;
      full_product = {64'd0, operand_a} * {64'd0, operand_b};
      low_partial  = {64'd0, full_product[63:0]} * {64'd0, reciprocal_setting};
      estimate     = {64'd0, full_product[127:64]} * {64'd0, reciprocal_setting}
                     + {64'd0, low_partial[127:64]};
      shift        = (exponent_setting >= 7'd64) ? exponent_setting - 7'd64 : 7'd0;
      quotient     = 64'(estimate >> shift);
      residue      = full_product[63:0] - quotient * modulus_setting;
      if (residue >= modulus_setting)
         residue = residue - modulus_setting;
      return residue;
   endfunction

   initial begin : result_sink
      int unsigned hold_left;
      int unsigned gap_left;
      hold_left = 0;
      gap_left  = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_request != 0) begin
            hold_left         = sink_hold_request;
            sink_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
            gap_left = idle_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_tvalid && !req_tready)
         input_stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_residues.size() == 0) begin
            $display("%0t: product_mod %h with no transaction outstanding", $time, rsp_tdata);
            error_count++;
         end else begin
            oldest_residue = expected_residues.pop_front();
            if (rsp_tdata !== oldest_residue) begin
               $display("%0t: product_mod mismatch: expected %h, actual %h",
                        $time, oldest_residue, rsp_tdata);
               error_count++;
            end
         end
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d transactions outstanding",
                  $time, expected_residues.size());
         $display("barrett_modular_multiplier_64_test: done, errors");
         $finish;
      end
   end

   task automatic send_operands(input logic [63:0] operand_a, input logic [63:0] operand_b);
      int unsigned gap;
      gap = (source_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {rand_word(), rand_word()};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {operand_b, operand_a};
      do @(posedge clock); while (!req_tready);
      expected_residues.insert(expected_residues.size(), barrett_residue(operand_a, operand_b));
      items_sent++;
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_residues.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input bmm_csr_index_type index, input logic [63:0] value);
      logic [63:0] stored;
      stored = (index == CSR_EXPONENT) ? {57'd0, value[6:0]} : value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         CSR_MODULUS:    modulus_setting    = value;
         CSR_RECIPROCAL: reciprocal_setting = value;
         CSR_EXPONENT:   exponent_setting   = value[6:0];
         default: ;
      endcase
      register_writes++;
      // read back through the same port
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored) begin
         $display("%0t: register %s readback mismatch: expected %h, actual %h",
                  $time, index.name(), stored, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_reduction(input logic [63:0] modulus, input logic [63:0] reciprocal,
                                input logic [6:0] exponent);
      drain_pipeline();
      write_register(CSR_MODULUS, modulus);
      write_register(CSR_RECIPROCAL, reciprocal);
      write_register(CSR_EXPONENT, {57'd0, exponent});
   endtask

   function automatic logic [63:0] reciprocal_of(input logic [63:0] modulus,
                                                 input logic [6:0] exponent);
      return 64'((128'd1 << exponent) / {64'd0, modulus});
   endfunction

   task automatic test_reset_defaults();
      send_operands(64'd0, 64'd0);
      send_operands(64'd1, 64'd1);
      send_operands('1, '1);
      send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
   endtask

   task automatic test_operand_extremes();
      logic [63:0] m;
      m = 64'hFFFF_FFFF_FFFF_FFC5;
      set_reduction(m, reciprocal_of(m, 7'd127), 7'd127);
      send_operands(64'd0, m - 1);
      send_operands(m - 1, m - 1);
      send_operands(64'd1, m - 1);
      send_operands('1, '1);
      send_operands(m, 64'd2);
      send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
   endtask

   task automatic test_short_exponent();
      logic [63:0] m;
      m = 64'hFFFF_FFFF_0000_0001;
      set_reduction(m, reciprocal_of(m, 7'd127), 7'd0);
      send_operands(m - 1, m - 2);
      send_operands(rand_word() % m, rand_word() % m);
      drain_pipeline();
      write_register(CSR_EXPONENT, 64'd63);
      send_operands(m - 1, m - 1);
      send_operands(rand_word() % m, rand_word() % m);
   endtask

   task automatic test_zero_modulus();
      set_reduction(64'd0, rand_word(), 7'd96);
      send_operands(rand_word(), rand_word());
      send_operands('1, '1);
      send_operands(64'd0, rand_word());
   endtask

   task automatic test_small_modulus();
      set_reduction(64'd3, reciprocal_of(64'd3, 7'd65), 7'd65);
      send_operands(64'd2, 64'd2);
      send_operands(64'd1, 64'd2);
      send_operands(64'd0, 64'd2);
   endtask

   task automatic pick_random_reduction();
      int unsigned bits;
      int unsigned top;
      logic [63:0] m;
      logic [6:0]  e;
      if ($urandom_range(0, 5) == 0)
         bits = $urandom_range(0, 1) ? 2 : 64;
      else
         bits = $urandom_range(2, 64);
      m = rand_word();
      if (bits < 64)
         m = m & ((64'd1 << bits) - 64'd1);
      m[bits - 1] = 1'b1;
      m[0]        = 1'b1;
      top = (bits + 63 > 127) ? 127 : bits + 63;
      e   = 7'($urandom_range(64, top));
      set_reduction(m, reciprocal_of(m, e), e);
   endtask

   function automatic logic [63:0] random_operand();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return modulus_setting - 1;
      else if (pick < 4)
         return rand_word();
      else
         return rand_word() % modulus_setting;
   endfunction

   task automatic test_random_moduli();
      repeat (6) begin
         pick_random_reduction();
         for (int n = 0; n < 60; n++) begin
            if (n % 20 == 0) begin
               source_gaps = $urandom_range(0, 2) != 0;
               sink_gaps   = $urandom_range(0, 2) != 0;
            end
            send_operands(random_operand(), random_operand());
         end
      end
   endtask

   task automatic test_output_backpressure();
      pick_random_reduction();
      source_gaps       = 1'b0;
      sink_gaps         = 1'b0;
      sink_hold_request = 300;
      repeat (40) send_operands(random_operand(), random_operand());
      sink_gaps = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_operand_extremes();
      test_short_exponent();
      test_zero_modulus();
      test_small_modulus();
      test_random_moduli();
      test_output_backpressure();
      drain_pipeline();
      $display("covered %0d operand pairs (%0d results) with %0d register writes: reset values,",
               items_sent, results_seen, register_writes);
      $display("extremes, zero modulus, exponents below 64 and random moduli; input stalled %0d cycles",
               input_stall_cycles);
      if (error_count == 0)
         $display("barrett_modular_multiplier_64_test: done, clean");
      else
         $display("barrett_modular_multiplier_64_test: done, errors");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/bmm_pkg.sv
sv/bmm_mul64.sv
sv/bmm_mul64_lo.sv
sv/barrett_modular_multiplier_64.sv
dv/barrett_modular_multiplier_64_test.sv
